// ===== sv/rc4_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the RC4 engine.
package rc4_pkg;

    // Default longest key in bytes.
    localparam int KEY_MAX_DEFAULT = 256;

    // Permutation geometry.
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = 8;

    typedef logic [7:0]         data_t;
    typedef logic [PERM_AW-1:0] perm_idx_t;

    // Index of the final key schedule step.
    localparam perm_idx_t LAST_IDX = perm_idx_t'(PERM_DEPTH - 1);

    // Request kinds on the input channel.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // One cycle of accesses to the permutation memory.
    typedef struct packed {
        perm_idx_t rd_addr;
        logic      wr_en;
        perm_idx_t wr_addr;
        data_t     wr_data;
        logic      clear;
    } perm_req_t;

endpackage

// ===== sv/rc4_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the RC4 engine requests and results.
interface rc4_in_if import rc4_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    data_t byte_in;
    logic  last;

    modport source (output valid, output cmd, output byte_in, output last, input ready);
    modport sink   (input valid, input cmd, input byte_in, input last, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t byte_out;
    logic  last_out;

    modport source (output valid, output byte_out, output last_out, input ready);
    modport sink   (input valid, input byte_out, input last_out, output ready);
endinterface

// ===== sv/rc4_perm_ram.sv =====
`timescale 1ns / 1ps
// Permutation memory with per-entry valid bits, identity fill and write bypass.
module rc4_perm_ram import rc4_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  perm_req_t req,
    output data_t     rd_data
);

    data_t                 perm_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic                  fwd_hit_reg;
    data_t                 rd_mem_reg;
    data_t                 fwd_data_reg;
    perm_idx_t             rd_addr_reg;

    // Storage array and registered read; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            perm_mem[req.wr_addr] <= req.wr_data;
        end
        rd_mem_reg   <= perm_mem[req.rd_addr];
        rd_addr_reg  <= req.rd_addr;
        fwd_data_reg <= req.wr_data;
    end

    // Valid bits: a cleared entry reads as its own index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.rd_addr];
            fwd_hit_reg  <= req.wr_en && !req.clear && (req.wr_addr == req.rd_addr);
        end
    end

    // A write to the entry being read in the same cycle wins over the array.
    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? rd_mem_reg   : rd_addr_reg;

endmodule

// ===== sv/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
// RC4 engine top level: control sequencer, key store and output register.
//
// Requests arrive on the feed channel. A key request (cmd = 0) stores one key
// byte; bytes beyond KEY_MAX are dropped. A key request with last set
// completes the key: the permutation returns to identity, the key schedule
// runs and both generator indices clear. The schedule runs a start state, then
// the read-j, swap and next states for each of 256 steps, and the feed is not
// ready meanwhile.
// A data request (cmd = 1) advances the generator and yields one result on the
// result channel: byte_out is byte_in XOR the keystream byte, last_out copies
// last. An accepted data request passes the read-j, swap and output states;
// the result is registered as the output state completes, and the next
// request can be taken in that same cycle. The data rate is set by the single
// read port of the permutation memory: each byte needs three dependent reads.
// The result register holds its value while the receiver stalls; a further
// data request then waits in its last step until the register frees up.
// Reset restores the identity permutation, zero indices and an empty key.
module rc4_stream_cipher import rc4_pkg::*; #(
    parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    rc4_in_if.sink    feed,
    rc4_out_if.source result
);

    localparam int CNT_W  = $clog2(KEY_MAX + 1);
    localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_D_RD_J  = 8'b0000_0010,
        ST_D_SWAP  = 8'b0000_0100,
        ST_D_OUT   = 8'b0000_1000,
        ST_K_START = 8'b0001_0000,
        ST_K_RD_J  = 8'b0010_0000,
        ST_K_SWAP  = 8'b0100_0000,
        ST_K_NEXT  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    perm_idx_t         gen_i_reg, gen_i_next;
    perm_idx_t         gen_j_reg, gen_j_next;
    logic [CNT_W-1:0]  key_count_reg, key_count_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [KIDX_W-1:0] pos_reg, pos_next;
    data_t             si_reg, si_next;
    perm_idx_t         t_reg, t_next;
    data_t             byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              out_valid_reg;
    data_t             out_byte_reg;
    logic              out_last_reg;

    data_t             key_mem [KEY_MAX];
    data_t             key_rd_reg;
    logic [KIDX_W-1:0] key_rd_addr;
    logic              key_wr_en;

    perm_req_t         perm_req;
    data_t             perm_rd;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              key_below;
    data_t             ks_byte;
    logic [CNT_W-1:0]  pos_inc;
    logic [KIDX_W-1:0] pos_adv;

    rc4_perm_ram u_perm (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (perm_req),
        .rd_data (perm_rd)
    );

    // Handshake and helper terms.
    assign out_free   = !out_valid_reg || result.ready;
    assign feed.ready = (state_reg == ST_IDLE) || ((state_reg == ST_D_OUT) && out_free);
    assign accept     = feed.valid && feed.ready;
    assign key_below  = key_count_reg < CNT_W'(KEY_MAX);
    assign pos_inc    = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_adv    = (pos_inc >= len_reg) ? '0 : pos_inc[KIDX_W-1:0];

    // Keystream byte: the entry at t after the swap; S[j] now holds S[i].
    assign ks_byte = (t_reg == gen_j_reg) ? si_reg : perm_rd;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        gen_i_next     = gen_i_reg;
        gen_j_next     = gen_j_reg;
        key_count_next = key_count_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        si_next        = si_reg;
        t_next         = t_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_load       = 1'b0;
        key_wr_en      = 1'b0;
        key_rd_addr    = pos_reg;
        perm_req       = '0;
        perm_req.rd_addr = t_reg;

        case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_D_RD_J:
            begin
                si_next          = perm_rd;
                gen_j_next       = gen_j_reg + perm_rd;
                perm_req.rd_addr = gen_j_reg + perm_rd;
                state_next       = ST_D_SWAP;
            end
            ST_D_SWAP:
            begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = gen_i_reg;
                perm_req.wr_data = perm_rd;
                t_next           = si_reg + perm_rd;
                perm_req.rd_addr = si_reg + perm_rd;
                state_next       = ST_D_OUT;
            end
            ST_D_OUT:
            begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = gen_j_reg;
                perm_req.wr_data = si_reg;
                perm_req.rd_addr = t_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_K_START:
            begin
                perm_req.rd_addr = gen_i_reg;
                state_next       = ST_K_RD_J;
            end
            ST_K_RD_J:
            begin
                si_next          = perm_rd;
                gen_j_next       = gen_j_reg + key_rd_reg + perm_rd;
                perm_req.rd_addr = gen_j_reg + key_rd_reg + perm_rd;
                state_next       = ST_K_SWAP;
            end
            ST_K_SWAP:
            begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = gen_i_reg;
                perm_req.wr_data = perm_rd;
                state_next       = ST_K_NEXT;
            end
            ST_K_NEXT:
            begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = gen_j_reg;
                perm_req.wr_data = si_reg;
                if (gen_i_reg == LAST_IDX)
                begin
                    gen_i_next = '0;
                    gen_j_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    gen_i_next       = gen_i_reg + 8'd1;
                    perm_req.rd_addr = gen_i_reg + 8'd1;
                    pos_next         = pos_adv;
                    key_rd_addr      = pos_adv;
                    state_next       = ST_K_RD_J;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new request, taken in idle or alongside a committed result.
        if (accept)
        begin
            if (feed.cmd == CMD_DATA)
            begin
                gen_i_next       = gen_i_reg + 8'd1;
                perm_req.rd_addr = gen_i_reg + 8'd1;
                byte_next        = feed.byte_in;
                last_next        = feed.last;
                state_next       = ST_D_RD_J;
            end
            else
            begin
                if (key_below)
                begin
                    key_wr_en      = 1'b1;
                    key_count_next = key_count_reg + CNT_W'(1);
                end
                if (feed.last)
                begin
                    len_next       = key_below ? (key_count_reg + CNT_W'(1)) : key_count_reg;
                    key_count_next = '0;
                    perm_req.clear = 1'b1;
                    gen_i_next     = '0;
                    gen_j_next     = '0;
                    pos_next       = '0;
                    state_next     = ST_K_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_i_reg     <= '0;
            gen_j_reg     <= '0;
            key_count_reg <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_i_reg     <= gen_i_next;
            gen_j_reg     <= gen_j_next;
            key_count_reg <= key_count_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the key store.
    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        t_reg    <= t_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (out_load)
        begin
            out_byte_reg <= byte_reg ^ ks_byte;
            out_last_reg <= last_reg;
        end
        if (key_wr_en)
        begin
            key_mem[key_count_reg[KIDX_W-1:0]] <= feed.byte_in;
        end
        key_rd_reg <= key_mem[key_rd_addr];
    end

    assign result.valid    = out_valid_reg;
    assign result.byte_out = out_byte_reg;
    assign result.last_out = out_last_reg;

    // A completed key always starts the schedule with an emptied key count.
    a_key_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (feed.cmd == CMD_KEY) && feed.last
        |=> (state_reg == ST_K_START) && (key_count_reg == '0))
        else $error("key schedule did not start after the final key byte");

    // The final schedule step leaves both indices at zero and returns to idle.
    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_K_NEXT) && (gen_i_reg == LAST_IDX)
        |=> (state_reg == ST_IDLE) && (gen_i_reg == '0) && (gen_j_reg == '0))
        else $error("key schedule ended with stale indices");

    // A committed data step lands in the result register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_D_OUT) && out_free
        |=> out_valid_reg && (out_byte_reg == $past(byte_reg ^ ks_byte)))
        else $error("result register missed a committed data byte");

    // The key count never passes the key store size.
    a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= CNT_W'(KEY_MAX))
        else $error("key count beyond key store size");

endmodule
